[design/pngd_pkg.sv]
`timescale 1ns / 1ps

package pngd_pkg;

   typedef enum logic [2:0] {
      PH_SIG,
      PH_LEN,
      PH_TYPE,
      PH_BODY,
      PH_CRC
   } phase_type;

   localparam logic [3:0] KIND_SIG     = 4'd0;
   localparam logic [3:0] KIND_LENGTH  = 4'd1;
   localparam logic [3:0] KIND_TYPE    = 4'd2;
   localparam logic [3:0] KIND_HEADER  = 4'd3;
   localparam logic [3:0] KIND_PALETTE = 4'd4;
   localparam logic [3:0] KIND_IMAGE   = 4'd5;
   localparam logic [3:0] KIND_OTHER   = 4'd6;
   localparam logic [3:0] KIND_CRC     = 4'd7;
   localparam logic [3:0] KIND_IGNORED = 4'd8;

   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_SIGNATURE     = 4'd1;
   localparam logic [3:0] ERR_AFTER_END     = 4'd2;
   localparam logic [3:0] ERR_HDR_LENGTH    = 4'd3;
   localparam logic [3:0] ERR_HDR_TWICE     = 4'd4;
   localparam logic [3:0] ERR_BEFORE_HDR    = 4'd5;
   localparam logic [3:0] ERR_PLTE_LENGTH   = 4'd6;
   localparam logic [3:0] ERR_PLTE_TWICE    = 4'd7;
   localparam logic [3:0] ERR_PLTE_AFTER    = 4'd8;
   localparam logic [3:0] ERR_EMPTY_DATA    = 4'd9;
   localparam logic [3:0] ERR_END_NO_DATA   = 4'd10;
   localparam logic [3:0] ERR_END_LENGTH    = 4'd11;

   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   localparam logic [31:0] HDR_LENGTH = 32'd13;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] field_count;
      logic [31:0] chunk_length;
      logic [30:0] len_quot;   // chunk_length / 3, built a byte at a time
      logic [1:0]  len_rem;    // chunk_length % 3
      logic [31:0] chunk_type;
      logic        header_seen;
      logic        palette_seen;
      logic        data_seen;
      logic        end_flag;
      logic [3:0]  sticky_error;
      logic [63:0] hdr_hi;
      logic [39:0] hdr_lo;
      logic [30:0] palette_count;
   } pngd_state_type;

   typedef struct packed {
      logic [3:0]  byte_kind;
      logic [7:0]  data_byte;
      logic [3:0]  error_code;
      logic        chunk_end;
      logic        end_seen;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic [7:0]  bit_depth;
      logic [7:0]  color_type;
      logic [23:0] header_methods;
      logic [30:0] palette_entries;
      logic        header_valid;
   } pngd_result_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0: val = 8'd137;
         3'd1: val = 8'd80;
         3'd2: val = 8'd78;
         3'd3: val = 8'd71;
         3'd4: val = 8'd13;
         3'd5: val = 8'd10;
         3'd6: val = 8'd26;
         3'd7: val = 8'd10;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

[design/pngd_step.sv]
`timescale 1ns / 1ps

module pngd_step import pngd_pkg::*; (
   input  pngd_state_type  cur_state,
   input  logic [7:0]      file_byte,
   output pngd_state_type  next_state,
   output pngd_result_type result
);

   logic [9:0]  div_num;
   logic [20:0] div_prod;
   logic [7:0]  div_quot;
   logic [9:0]  div_back;
   logic [9:0]  div_rem;
   logic [31:0] type_new;
   logic [3:0]  type_err;
   logic [3:0]  kind;
   logic        cend;
   pngd_state_type nxt;

   // Long division by 3, one length byte a step: 256 = 1 mod 3,
   // and v * 683 >> 11 is exact for v below 768.
   assign div_num  = {cur_state.len_rem, file_byte};
   assign div_prod = {11'd0, div_num} * 21'd683;
   assign div_quot = div_prod[18:11];
   assign div_back = {1'b0, div_quot, 1'b0} + {2'b00, div_quot};
   assign div_rem  = div_num - div_back;

   assign type_new = {cur_state.chunk_type[23:0], file_byte};

   always_comb begin
      type_err = ERR_NONE;
      if (type_new == TYPE_IHDR) begin
         if (cur_state.header_seen) type_err = ERR_HDR_TWICE;
         else if (cur_state.chunk_length != HDR_LENGTH) type_err = ERR_HDR_LENGTH;
      end else if (!cur_state.header_seen) begin
         type_err = ERR_BEFORE_HDR;
      end else if (type_new == TYPE_PLTE) begin
         if (cur_state.palette_seen) type_err = ERR_PLTE_TWICE;
         else if (cur_state.len_rem != 2'd0) type_err = ERR_PLTE_LENGTH;
         else if (cur_state.data_seen) type_err = ERR_PLTE_AFTER;
      end else if (type_new == TYPE_IDAT) begin
         if (cur_state.chunk_length == 32'd0) type_err = ERR_EMPTY_DATA;
      end else if (type_new == TYPE_IEND) begin
         if (!cur_state.data_seen) type_err = ERR_END_NO_DATA;
         else if (cur_state.chunk_length != 32'd0) type_err = ERR_END_LENGTH;
      end
   end

   always_comb begin
      nxt  = cur_state;
      kind = KIND_IGNORED;
      cend = 1'b0;
      if (cur_state.sticky_error != ERR_NONE) begin
         kind = KIND_IGNORED;
      end else if (cur_state.end_flag) begin
         nxt.sticky_error = ERR_AFTER_END;
      end else begin
         case (cur_state.phase)
            PH_SIG: begin
               kind = KIND_SIG;
               if (file_byte != sig_byte(cur_state.field_count[2:0])) begin
                  nxt.sticky_error = ERR_SIGNATURE;
               end else if (cur_state.field_count >= 32'd7) begin
                  nxt.phase       = PH_LEN;
                  nxt.field_count = 32'd0;
               end else begin
                  nxt.field_count = cur_state.field_count + 32'd1;
               end
            end
            PH_LEN: begin
               kind             = KIND_LENGTH;
               nxt.chunk_length = {cur_state.chunk_length[23:0], file_byte};
               nxt.len_quot     = {cur_state.len_quot[22:0], div_quot};
               nxt.len_rem      = div_rem[1:0];
               if (cur_state.field_count >= 32'd3) begin
                  nxt.phase       = PH_TYPE;
                  nxt.field_count = 32'd0;
               end else begin
                  nxt.field_count = cur_state.field_count + 32'd1;
               end
            end
            PH_TYPE: begin
               kind           = KIND_TYPE;
               nxt.chunk_type = type_new;
               if (cur_state.field_count >= 32'd3) begin
                  nxt.field_count = 32'd0;
                  if (type_err != ERR_NONE) begin
                     nxt.sticky_error = type_err;
                  end else begin
                     if (type_new == TYPE_PLTE) begin
                        nxt.palette_seen  = 1'b1;
                        nxt.palette_count = cur_state.len_quot;
                     end else if (type_new == TYPE_IDAT) begin
                        nxt.data_seen = 1'b1;
                     end
                     nxt.phase = (cur_state.chunk_length == 32'd0) ? PH_CRC : PH_BODY;
                  end
               end else begin
                  nxt.field_count = cur_state.field_count + 32'd1;
               end
            end
            PH_BODY: begin
               if (cur_state.chunk_type == TYPE_IHDR) begin
                  kind = KIND_HEADER;
                  if (cur_state.field_count < 32'd8)
                     nxt.hdr_hi = {cur_state.hdr_hi[55:0], file_byte};
                  else
                     nxt.hdr_lo = {cur_state.hdr_lo[31:0], file_byte};
               end else if (cur_state.chunk_type == TYPE_PLTE) begin
                  kind = KIND_PALETTE;
               end else if (cur_state.chunk_type == TYPE_IDAT) begin
                  kind = KIND_IMAGE;
               end else begin
                  kind = KIND_OTHER;
               end
               if (cur_state.field_count + 32'd1 == cur_state.chunk_length) begin
                  nxt.phase       = PH_CRC;
                  nxt.field_count = 32'd0;
               end else begin
                  nxt.field_count = cur_state.field_count + 32'd1;
               end
            end
            PH_CRC: begin
               kind = KIND_CRC;
               if (cur_state.field_count >= 32'd3) begin
                  cend = 1'b1;
                  if (cur_state.chunk_type == TYPE_IHDR) nxt.header_seen = 1'b1;
                  if (cur_state.chunk_type == TYPE_IEND) nxt.end_flag = 1'b1;
                  nxt.phase        = PH_LEN;
                  nxt.field_count  = 32'd0;
                  nxt.chunk_length = 32'd0;
                  nxt.len_quot     = 31'd0;
                  nxt.len_rem      = 2'd0;
                  nxt.chunk_type   = 32'd0;
               end else begin
                  nxt.field_count = cur_state.field_count + 32'd1;
               end
            end
            default: begin
               kind = KIND_IGNORED;
            end
         endcase
      end
   end

   assign next_state = nxt;

   always_comb begin
      result.byte_kind       = kind;
      result.data_byte       = file_byte;
      result.error_code      = nxt.sticky_error;
      result.chunk_end       = cend;
      result.end_seen        = nxt.end_flag;
      result.palette_entries = nxt.palette_count;
      result.header_valid    = nxt.header_seen;
      if (nxt.header_seen) begin
         result.image_width    = nxt.hdr_hi[63:32];
         result.image_height   = nxt.hdr_hi[31:0];
         result.bit_depth      = nxt.hdr_lo[39:32];
         result.color_type     = nxt.hdr_lo[31:24];
         result.header_methods = nxt.hdr_lo[23:0];
      end else begin
         result.image_width    = 32'd0;
         result.image_height   = 32'd0;
         result.bit_depth      = 8'd0;
         result.color_type     = 8'd0;
         result.header_methods = 24'd0;
      end
   end

endmodule

[design/png_chunk_deframer.sv]
// The result transaction of an accepted byte is registered and presented in the next cycle.
// Throughput: one byte per cycle; the parse state and the result register
// both advance on every accepted transaction, so input is taken while a
// result waits as long as the result side is not stalled.
// Reset (synchronous, active high) returns the parser to the signature check,
// clears all chunk, header and error state and the response valid flag; result_ff is not reset.
`timescale 1ns / 1ps

module png_chunk_deframer import pngd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_byte_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_chunk_end,
   output logic        rsp_end_seen,
   output logic [31:0] rsp_image_width,
   output logic [31:0] rsp_image_height,
   output logic [7:0]  rsp_bit_depth,
   output logic [7:0]  rsp_color_type,
   output logic [23:0] rsp_header_methods,
   output logic [30:0] rsp_palette_entries,
   output logic        rsp_header_valid
);

   pngd_state_type  state_ff, state_in;
   pngd_result_type result_ff, result_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   pngd_step u_step (
      .cur_state  (state_ff),
      .file_byte  (req_file_byte),
      .next_state (state_in),
      .result     (result_in)
   );

   always_comb begin
      if (req_accept) rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_kind       = result_ff.byte_kind;
   assign rsp_data_byte       = result_ff.data_byte;
   assign rsp_error_code      = result_ff.error_code;
   assign rsp_chunk_end       = result_ff.chunk_end;
   assign rsp_end_seen        = result_ff.end_seen;
   assign rsp_image_width     = result_ff.image_width;
   assign rsp_image_height    = result_ff.image_height;
   assign rsp_bit_depth       = result_ff.bit_depth;
   assign rsp_color_type      = result_ff.color_type;
   assign rsp_header_methods  = result_ff.header_methods;
   assign rsp_palette_entries = result_ff.palette_entries;
   assign rsp_header_valid    = result_ff.header_valid;

   // first error sticks
   assert property (@(posedge clock) disable iff (reset)
      state_ff.sticky_error != ERR_NONE |=> state_ff.sticky_error == $past(state_ff.sticky_error))
      else $error("sticky error changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.chunk_end |-> result_ff.byte_kind == KIND_CRC)
      else $error("chunk end flagged on a non-CRC byte");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_SIG |-> state_ff.field_count < 32'd8)
      else $error("signature index out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.byte_kind == KIND_HEADER |-> !result_ff.header_valid)
      else $error("header body byte after header completed");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_BODY && state_ff.sticky_error == ERR_NONE
         |-> state_ff.chunk_length != 32'd0)
      else $error("body phase entered for an empty chunk");

endmodule
